>>> hw/rtl/cau_pkg.sv
// cau_pkg: opcodes and status codes of the complex arithmetic unit
// no dependencies; used by complex_arithmetic_unit
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

endpackage

>>> hw/rtl/complex_arithmetic_unit.sv
// complex_arithmetic_unit: pipelined complex add, sub, mul, div and conjugate
// depends on cau_pkg
//
// One complex operation per beat, a new beat accepted every cycle unless the output stalls.
// Every beat passes through the same stages: an input register, a product stage with six
// multipliers, a sum and magnitude stage, one restoring-division stage per quotient bit
// (2*DATA_WIDTH + FRAC_BITS of them, shared by real and imaginary parts), and a saturating
// output register. Non-divide operations ride the divider stages unchanged.
// The whole pipe stalls together while the output beat is not taken; nothing is dropped.
// Operands and results are signed fixed point with FRAC_BITS fraction bits; products are
// floored, quotients truncate toward zero, out-of-range parts saturate (status 1), and a
// divide by zero returns zero with status 2. Unused opcodes return zero with status 0.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  localparam int InW  = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // a_re, a_im, b_re, b_im, zero pad
  input  logic [2:0]      s_axis_tuser_i,   // req_type
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // res_re, res_im, zero pad
  output logic [1:0]      m_axis_tuser_o    // status
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int NW = PW + FRAC_BITS;
  localparam int WW = NW + 1;
  localparam logic signed [WW-1:0] SatHi = WW'({1'b0, {(DW - 1) {1'b1}}});
  localparam logic signed [WW-1:0] SatLo = -SatHi - WW'(1);

  typedef struct packed {
    logic                 is_div;
    logic                 divz;
    logic                 neg_re;
    logic                 neg_im;
    logic signed [WW-1:0] w_re;
    logic signed [WW-1:0] w_im;
    logic [PW-1:0]        den;
    logic [NW-1:0]        n_re;
    logic [NW-1:0]        n_im;
    logic [PW-1:0]        r_re;
    logic [PW-1:0]        r_im;
  } dstage_t;

  logic en;
  logic m_v_q;

  assign en              = !m_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: input register
  logic                 s1_v_q;
  logic [2:0]           s1_op_q;
  logic signed [DW-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= s_axis_tuser_i;
      s1_ar_q <= s_axis_tdata_i[0*DW +: DW];
      s1_ai_q <= s_axis_tdata_i[1*DW +: DW];
      s1_br_q <= s_axis_tdata_i[2*DW +: DW];
      s1_bi_q <= s_axis_tdata_i[3*DW +: DW];
    end
  end

  // stage 2: products and the simple operations
  logic signed [DW:0] alt_re, alt_im;

  always_comb begin
    alt_re = '0;
    alt_im = '0;
    case (s1_op_q)
      cau_pkg::OP_ADD: begin
        alt_re = (DW+1)'(s1_ar_q) + (DW+1)'(s1_br_q);
        alt_im = (DW+1)'(s1_ai_q) + (DW+1)'(s1_bi_q);
      end
      cau_pkg::OP_SUB: begin
        alt_re = (DW+1)'(s1_ar_q) - (DW+1)'(s1_br_q);
        alt_im = (DW+1)'(s1_ai_q) - (DW+1)'(s1_bi_q);
      end
      cau_pkg::OP_CONJ: begin
        alt_re = (DW+1)'(s1_ar_q);
        alt_im = -(DW+1)'(s1_ai_q);
      end
      default: begin
        alt_re = '0;
        alt_im = '0;
      end
    endcase
  end

  logic                 s2_v_q;
  logic [2:0]           s2_op_q;
  logic signed [PW-1:0] s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q, s2_p5_q;
  logic signed [DW:0]   s2_alt_re_q, s2_alt_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q     <= s1_op_q;
      s2_p0_q     <= PW'(s1_ar_q) * PW'(s1_br_q);
      s2_p1_q     <= PW'(s1_ai_q) * PW'(s1_bi_q);
      s2_p2_q     <= PW'(s1_ar_q) * PW'(s1_bi_q);
      s2_p3_q     <= PW'(s1_ai_q) * PW'(s1_br_q);
      s2_p4_q     <= PW'(s1_br_q) * PW'(s1_br_q);
      s2_p5_q     <= PW'(s1_bi_q) * PW'(s1_bi_q);
      s2_alt_re_q <= alt_re;
      s2_alt_im_q <= alt_im;
    end
  end

  // stage 3: sums, divisor and dividend magnitudes
  logic signed [PW:0] nre, nim, mre, mim, mag_re, mag_im;
  logic [PW-1:0]      den;
  dstage_t            s3_d;

  always_comb begin
    nre    = (PW+1)'(s2_p0_q) + (PW+1)'(s2_p1_q);
    nim    = (PW+1)'(s2_p3_q) - (PW+1)'(s2_p2_q);
    mre    = (PW+1)'(s2_p0_q) - (PW+1)'(s2_p1_q);
    mim    = (PW+1)'(s2_p2_q) + (PW+1)'(s2_p3_q);
    den    = $unsigned(s2_p4_q) + $unsigned(s2_p5_q);
    mag_re = nre[PW] ? -nre : nre;
    mag_im = nim[PW] ? -nim : nim;

    s3_d        = '0;
    s3_d.is_div = (s2_op_q == cau_pkg::OP_DIV);
    s3_d.divz   = s3_d.is_div && (den == '0);
    s3_d.neg_re = nre[PW];
    s3_d.neg_im = nim[PW];
    s3_d.den    = den;
    s3_d.n_re   = NW'(mag_re[PW-1:0]) << FRAC_BITS;
    s3_d.n_im   = NW'(mag_im[PW-1:0]) << FRAC_BITS;
    if (s2_op_q == cau_pkg::OP_MUL) begin
      s3_d.w_re = WW'(mre >>> FRAC_BITS);
      s3_d.w_im = WW'(mim >>> FRAC_BITS);
    end else begin
      s3_d.w_re = WW'(s2_alt_re_q);
      s3_d.w_im = WW'(s2_alt_im_q);
    end
  end

  // divider pipe: entry 0 is the stage 3 register, one quotient bit per stage
  dstage_t   dst_q [NW+1];
  logic      dv_q  [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dst_q[0] <= s3_d;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [PW:0] rn_re, rn_im;
    logic        ge_re, ge_im;
    dstage_t     nxt;

    always_comb begin
      rn_re    = {dst_q[k].r_re, dst_q[k].n_re[NW-1]};
      rn_im    = {dst_q[k].r_im, dst_q[k].n_im[NW-1]};
      ge_re    = rn_re >= {1'b0, dst_q[k].den};
      ge_im    = rn_im >= {1'b0, dst_q[k].den};
      nxt      = dst_q[k];
      nxt.r_re = ge_re ? PW'(rn_re - {1'b0, dst_q[k].den}) : rn_re[PW-1:0];
      nxt.r_im = ge_im ? PW'(rn_im - {1'b0, dst_q[k].den}) : rn_im[PW-1:0];
      nxt.n_re = {dst_q[k].n_re[NW-2:0], ge_re};
      nxt.n_im = {dst_q[k].n_im[NW-2:0], ge_im};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dst_q[k+1] <= nxt;
      end
    end
  end

  // output stage: sign, select, saturate
  dstage_t               fin;
  logic signed [WW-1:0]  q_re, q_im, v_re, v_im, o_re, o_im;
  logic                  sat;
  cau_pkg::status_e      st;

  always_comb begin
    fin  = dst_q[NW];
    q_re = fin.neg_re ? -$signed({1'b0, fin.n_re}) : $signed({1'b0, fin.n_re});
    q_im = fin.neg_im ? -$signed({1'b0, fin.n_im}) : $signed({1'b0, fin.n_im});
    if (fin.is_div) begin
      v_re = fin.divz ? '0 : q_re;
      v_im = fin.divz ? '0 : q_im;
    end else begin
      v_re = fin.w_re;
      v_im = fin.w_im;
    end
    sat  = 1'b0;
    o_re = v_re;
    o_im = v_im;
    if (v_re > SatHi) begin
      o_re = SatHi;
      sat  = 1'b1;
    end else if (v_re < SatLo) begin
      o_re = SatLo;
      sat  = 1'b1;
    end
    if (v_im > SatHi) begin
      o_im = SatHi;
      sat  = 1'b1;
    end else if (v_im < SatLo) begin
      o_im = SatLo;
      sat  = 1'b1;
    end
    if (fin.divz) begin
      st = cau_pkg::ST_DIVZ;
    end else if (sat) begin
      st = cau_pkg::ST_SAT;
    end else begin
      st = cau_pkg::ST_OK;
    end
  end

  logic [DW-1:0] m_re_q, m_im_q;
  logic [1:0]    m_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= dv_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_re_q <= o_re[DW-1:0];
      m_im_q <= o_im[DW-1:0];
      m_st_q <= st;
    end
  end

  assign m_axis_tvalid_o = m_v_q;
  assign m_axis_tdata_o  = OutW'({m_im_q, m_re_q});
  assign m_axis_tuser_o  = m_st_q;

  // a held output beat freezes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // divide by zero always gives a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == cau_pkg::ST_DIVZ) |-> (m_re_q == '0 && m_im_q == '0))
    else $error("divide by zero with nonzero result");

  // saturation flag means some part sits on a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == cau_pkg::ST_SAT) |->
      (m_re_q == SatHi[DW-1:0] || m_re_q == SatLo[DW-1:0] ||
       m_im_q == SatHi[DW-1:0] || m_im_q == SatLo[DW-1:0]))
    else $error("saturation flagged without a clamped part");

  // a stalled pipe holds the valid bit of its last divider stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q[NW]))
    else $error("divider stage moved during stall");

endmodule
